// ===== rtl/bsbp_pkg.sv =====
// bsbp_pkg: shared types and constants for the box screen bounds projector
// no dependencies
package bsbp_pkg;

  localparam int unsigned MAX_IMAGE_DIM   = 8192;
  localparam int unsigned PIXEL_FRAC_BITS = 4;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned DIM_W   = 14;
  localparam int unsigned SCR_W   = 18;
  localparam int unsigned OUT_W   = 18;
  localparam int unsigned ACC_W   = 50;
  localparam int unsigned CLIP_W  = 38;
  localparam int unsigned MUL_A_W = 40;
  localparam int unsigned MUL_B_W = 19;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned NUM_W   = 57;
  localparam int unsigned DEN_W   = CLIP_W + 1;
  localparam int unsigned BND_W   = 24;
  localparam int unsigned IDX_W   = 3;

  localparam logic signed [BND_W-1:0] BND_MAX = 24'sh7FFFFF;
  localparam logic signed [BND_W-1:0] BND_MIN = -24'sh800000;

  localparam logic [IDX_W-1:0] REG_ROW_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW_W  = 3'd3;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_PMUL,
    ST_DSTART,
    ST_DWAIT,
    ST_FOLD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             done;
    logic             rem_nz;
    logic [NUM_W-1:0] quo;
  } div_res_t;

endpackage

// ===== rtl/box_screen_bounds_projector.sv =====
// box_screen_bounds_projector: projects streamed box corners to a screen bounding box
// depends on bsbp_pkg and bsbp_div
//
// Corners arrive one word at a time; one shared 40x19 signed multiplier forms the
// clip x, y and w sums (twelve products) and the two scaled numerators, and a
// one-bit-per-cycle divider runs 57 steps for each of the two screen coordinates.
// s_axis_tready is low while a corner is processed, whether it is visible or
// behind the camera. The bounds word of a box is produced after its last corner
// and waits in an output register.
module box_screen_bounds_projector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // corner_x, corner_y, corner_z
  input  logic        s_axis_tlast,   // last_corner
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // min_x, min_y, max_x, max_y
  output logic [1:0]  m_axis_tuser,   // clipped, valid_res
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [bsbp_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import bsbp_pkg::*;

  logic [63:0] row_x_q, row_y_q, row_w_q;
  logic [DIM_W-1:0] width_q, height_q;

  state_e state_q, state_d;
  logic [3:0] step_q, step_d;
  logic sel_y_q, sel_y_d;
  logic last_q, last_d;
  logic behind_q, behind_d;
  logic signed [COORD_W-1:0] cx_in_q, cy_in_q, cz_in_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, acc_sum;
  logic signed [CLIP_W-1:0] clx_q, cly_q, clw_q, clx_d, cly_d, clw_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [BND_W-1:0] px_q, px_d, qv;
  logic signed [BND_W-1:0] mnx_q, mny_q, mxx_q, mxy_q;
  logic signed [BND_W-1:0] mnx_d, mny_d, mxx_d, mxy_d;
  logic neg_q, neg_d;
  logic out_v_q, out_v_d;
  logic [71:0] out_data_q, out_data_d;
  logic [1:0] out_user_q, out_user_d;
  logic [63:0] row_sel;
  logic [COEF_W-1:0] coef;
  logic [DIM_W-1:0] wd, ht;
  logic [SCR_W-1:0] sw, sh;
  logic div_start;
  logic [NUM_W-1:0] div_num;
  logic [PROD_W-1:0] prod_abs;
  div_res_t div_res;
  logic [NUM_W:0] mag;
  logic [OUT_W-1:0] ca, cb, cc, cd;
  logic clip_f, valid_f;

  function automatic logic [OUT_W-1:0] clampb(logic signed [BND_W-1:0] v,
                                              logic [SCR_W-1:0] hi);
    logic [OUT_W-1:0] r;
    if (v < 0) r = '0;
    else if ($unsigned(v) > BND_W'(hi)) r = OUT_W'(hi);
    else r = OUT_W'($unsigned(v));
    return r;
  endfunction

  assign wd = (width_q > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : width_q;
  assign ht = (height_q > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : height_q;
  assign sw = SCR_W'(wd) << PIXEL_FRAC_BITS;
  assign sh = SCR_W'(ht) << PIXEL_FRAC_BITS;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q  <= 64'd4096;
      row_y_q  <= 64'd4096 << 16;
      row_w_q  <= 64'd4096 << 48;
      width_q  <= DIM_W'(1920);
      height_q <= DIM_W'(1080);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROW_X:  row_x_q  <= cfg_data_i;
        REG_ROW_Y:  row_y_q  <= cfg_data_i;
        REG_ROW_Z:  ;  // clip z does not reach the screen bounds
        REG_ROW_W:  row_w_q  <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (step_q[3:2])
      2'd0:    row_sel = row_x_q;
      2'd1:    row_sel = row_y_q;
      default: row_sel = row_w_q;
    endcase
    case (step_q[1:0])
      2'd0:    coef = row_sel[15:0];
      2'd1:    coef = row_sel[31:16];
      2'd2:    coef = row_sel[47:32];
      default: coef = row_sel[63:48];
    endcase
    if (state_q == ST_PMUL) begin
      mul_a = sel_y_q ? MUL_A_W'(clw_q) - MUL_A_W'(cly_q)
                      : MUL_A_W'(clx_q) + MUL_A_W'(clw_q);
      mul_b = $signed({1'b0, sel_y_q ? sh : sw});
    end else begin
      case (step_q[1:0])
        2'd0:    mul_a = MUL_A_W'(cx_in_q);
        2'd1:    mul_a = MUL_A_W'(cy_in_q);
        2'd2:    mul_a = MUL_A_W'(cz_in_q);
        default: mul_a = MUL_A_W'(65536);
      endcase
      mul_b = MUL_B_W'($signed(coef));
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  assign acc_sum  = acc_q + prod_q[ACC_W-1:0];
  assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign div_num  = prod_abs[NUM_W-1:0];

  bsbp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({clw_q, 1'b0}),
    .res_o   (div_res)
  );

  // floor quotient, saturated to the bound range
  always_comb begin
    mag = {1'b0, div_res.quo} + (NUM_W+1)'(neg_q & div_res.rem_nz);
    if (!neg_q) begin
      qv = (div_res.quo > NUM_W'(BND_MAX)) ? BND_MAX : BND_W'(div_res.quo);
    end else begin
      qv = (mag > (NUM_W+1)'(24'h800000)) ? BND_MIN : BND_W'(-mag[BND_W-1:0]);
    end
  end

  always_comb begin
    ca = clampb(mnx_q, sw);
    cb = clampb(mny_q, sh);
    cc = clampb(mxx_q, sw);
    cd = clampb(mxy_q, sh);
    clip_f = (mnx_q < 0) || (mny_q < 0) ||
             (mxx_q > $signed(BND_W'(sw))) || (mxy_q > $signed(BND_W'(sh)));
    valid_f = (cc > ca) && (cd > cb);
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    sel_y_d    = sel_y_q;
    last_d     = last_q;
    behind_d   = behind_q;
    acc_d      = acc_q;
    clx_d      = clx_q;
    cly_d      = cly_q;
    clw_d      = clw_q;
    px_d       = px_q;
    neg_d      = neg_q;
    mnx_d      = mnx_q;
    mny_d      = mny_q;
    mxx_d      = mxx_q;
    mxy_d      = mxy_q;
    out_v_d    = out_v_q & ~m_axis_tready;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    div_start  = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          last_d  = s_axis_tlast;
          step_d  = '0;
          acc_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        acc_d   = acc_sum;
        state_d = ST_MUL;
        if (step_q[1:0] == 2'd3) begin
          acc_d = '0;
          case (step_q[3:2])
            2'd0:    clx_d = acc_sum[ACC_W-1:12];
            2'd1:    cly_d = acc_sum[ACC_W-1:12];
            default: clw_d = acc_sum[ACC_W-1:12];
          endcase
        end
        step_d = step_q + 1'b1;
        if (step_q == 4'd11) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (wd == '0 || ht == '0 || clw_q <= 0) begin
          behind_d = 1'b1;
          state_d  = last_q ? ST_EMIT : ST_IDLE;
        end else begin
          sel_y_d = 1'b0;
          state_d = ST_PMUL;
        end
      end
      ST_PMUL: state_d = ST_DSTART;
      ST_DSTART: begin
        div_start = 1'b1;
        neg_d     = prod_q[PROD_W-1];
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_res.done) begin
          if (!sel_y_q) begin
            px_d    = qv;
            sel_y_d = 1'b1;
            state_d = ST_PMUL;
          end else begin
            if (px_q < mnx_q) mnx_d = px_q;
            if (px_q > mxx_q) mxx_d = px_q;
            if (qv < mny_q) mny_d = qv;
            if (qv > mxy_q) mxy_d = qv;
            state_d = ST_FOLD;
          end
        end
      end
      ST_FOLD: state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d = 1'b1;
          if (behind_q) begin
            out_data_d = '0;
            out_user_d = '0;
          end else begin
            out_data_d = {cd, cc, cb, ca};
            out_user_d = {valid_f, clip_f};
          end
          mnx_d    = BND_MAX;
          mny_d    = BND_MAX;
          mxx_d    = BND_MIN;
          mxy_d    = BND_MIN;
          behind_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      sel_y_q  <= 1'b0;
      last_q   <= 1'b0;
      behind_q <= 1'b0;
      out_v_q  <= 1'b0;
      mnx_q    <= BND_MAX;
      mny_q    <= BND_MAX;
      mxx_q    <= BND_MIN;
      mxy_q    <= BND_MIN;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      sel_y_q  <= sel_y_d;
      last_q   <= last_d;
      behind_q <= behind_d;
      out_v_q  <= out_v_d;
      mnx_q    <= mnx_d;
      mny_q    <= mny_d;
      mxx_q    <= mxx_d;
      mxy_q    <= mxy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      cx_in_q <= s_axis_tdata[31:0];
      cy_in_q <= s_axis_tdata[63:32];
      cz_in_q <= s_axis_tdata[95:64];
    end
    acc_q      <= acc_d;
    clx_q      <= clx_d;
    cly_q      <= cly_d;
    clw_q      <= clw_d;
    px_q       <= px_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== rtl/bsbp_div.sv =====
// bsbp_div: restoring divider, one quotient bit per cycle
// depends on bsbp_pkg
module bsbp_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [bsbp_pkg::NUM_W-1:0] num_i,
  input  logic [bsbp_pkg::DEN_W-1:0] den_i,
  output bsbp_pkg::div_res_t     res_o
);
  import bsbp_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial  = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    ge     = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (trial - {1'b0, den_q}) : trial;
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign res_o.done   = done_q;
  assign res_o.rem_nz = rem_q != '0;
  assign res_o.quo    = quo_q;

endmodule

// ===== rtl/bsbp_checker.sv =====
// bsbp_checker: port-level checks for box_screen_bounds_projector, with its bind
// depends on box_screen_bounds_projector
module bsbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed under stall");

  // a corner keeps the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted back to back");

  // valid box has positive extent
  a_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata[53:36] > m_axis_tdata[17:0]) &&
      (m_axis_tdata[71:54] > m_axis_tdata[35:18]))
    else $error("valid box with empty area");

  // all-zero bounds are never flagged valid
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata == '0) |-> !m_axis_tuser[1])
    else $error("empty bounds flagged valid");

endmodule

bind box_screen_bounds_projector bsbp_checker u_bsbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
